### design/bolc_pkg.sv
// ============================================================================
// bolc_pkg
// Types, constants and helpers shared by the byte offset to line and UTF-16
// column block.
// ============================================================================
`default_nettype none

package bolc_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;
    localparam int POS_WIDTH   = 32;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [POS_WIDTH-1:0]   t_pos;

    localparam t_count COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam t_pos   POS_MAX   = {POS_WIDTH{1'b1}};
    localparam logic [OUT_WIDTH-1:0] OUT_MAX = {OUT_WIDTH{1'b1}};

    localparam logic [7:0] ASCII_LIMIT  = 8'h80;
    localparam logic [7:0] NEWLINE      = 8'h0A;
    localparam logic [7:0] MASK_LEAD2   = 8'hE0;
    localparam logic [7:0] CODE_LEAD2   = 8'hC0;
    localparam logic [7:0] MASK_LEAD3   = 8'hF0;
    localparam logic [7:0] CODE_LEAD3   = 8'hE0;
    localparam logic [7:0] MASK_LEAD4   = 8'hF8;
    localparam logic [7:0] CODE_LEAD4   = 8'hF0;
    localparam logic [7:0] MASK_CONT    = 8'hC0;
    localparam logic [7:0] CODE_CONT    = 8'h80;

    localparam logic [1:0] SEQ_NONE  = 2'd0;
    localparam logic [1:0] SEQ_TWO   = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR  = 2'd3;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       byte_present;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] line_number;
        logic [OUT_WIDTH-1:0] column_units;
    } t_out_item;

    typedef struct packed {
        t_count     line_count;
        t_count     column_count;
        t_pos       byte_position;
        logic [1:0] pending_length;
        logic [1:0] pending_seen;
        logic       pending_astral;
        logic [2:0] pending_lead_bits;
        logic [1:0] pending_counted;
    } t_text_state;

    function automatic logic [OUT_WIDTH-1:0] sat_out(input t_count value);
        logic [63:0] wide;
        wide = 64'(value);
        return (wide > 64'(OUT_MAX)) ? OUT_MAX : wide[OUT_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

### design/byte_offset_to_line_utf16_column.sv
// A final byte's result is registered in r_out when that byte, held in r_in, advances.
// Throughput: one byte per cycle; the input stalls only while a result is
// waiting and the next final byte would replace it.
// Reset (synchronous, active low) clears the counters, any open sequence,
// the stop offset and both valid flags.
// ============================================================================
// byte_offset_to_line_utf16_column
// Streams UTF-8 text and reports the line and UTF-16 column at a byte offset.
// ============================================================================
`default_nettype none

module byte_offset_to_line_utf16_column (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  wire bolc_pkg::t_in_item i_in_data,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output bolc_pkg::t_out_item     o_out_data,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire bolc_pkg::t_pos     i_cfg_data
);

    bolc_pkg::t_in_item    r_in;
    logic                  r_in_valid;
    bolc_pkg::t_text_state r_state;
    bolc_pkg::t_text_state n_state;
    bolc_pkg::t_pos        r_stop;
    logic                  r_out_valid;
    bolc_pkg::t_out_item   r_out;
    bolc_pkg::t_out_item   n_out;
    logic                  advance;
    logic                  in_take;
    logic                  out_take;

    assign advance    = r_in_valid && !(r_in.last_byte && r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    bolc_step u_step (
        .i_item        (r_in),
        .i_state       (r_state),
        .i_stop_offset (r_stop),
        .o_next        (n_state),
        .o_result      (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (advance && r_in.last_byte) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= '0;
            r_stop      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_stop <= i_cfg_data;
            end
            if (advance && r_in.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### design/bolc_step.sv
// ============================================================================
// bolc_step
// Combinational decode of one byte: next text state and the line and column
// result for a final transaction.
// ============================================================================
`default_nettype none

module bolc_step (
    input  wire bolc_pkg::t_in_item    i_item,
    input  wire bolc_pkg::t_text_state i_state,
    input  wire bolc_pkg::t_pos        i_stop_offset,
    output bolc_pkg::t_text_state      o_next,
    output bolc_pkg::t_out_item        o_result
);

    localparam int COUNT_WIDTH_P1 = bolc_pkg::COUNT_WIDTH + 1;

    logic                 below;
    logic                 is_cont;
    logic [7:0]           b;
    logic                 do_fresh;
    logic                 newline;
    logic [2:0]           inc;
    logic [1:0]           seen_inc;
    logic [COUNT_WIDTH_P1-1:0] col_sum;
    bolc_pkg::t_text_state mid;
    bolc_pkg::t_count     col_base;
    bolc_pkg::t_count     col_final;

    assign b       = i_item.byte_value;
    assign below   = i_state.byte_position < i_stop_offset;
    assign is_cont = (b & bolc_pkg::MASK_CONT) == bolc_pkg::CODE_CONT;

    always_comb begin
        mid      = i_state;
        inc      = 3'd0;
        newline  = 1'b0;
        do_fresh = 1'b0;
        seen_inc = i_state.pending_seen + 2'd1;
        if (i_item.byte_present) begin
            if (i_state.pending_length != bolc_pkg::SEQ_NONE) begin
                if (is_cont) begin
                    mid.pending_seen = seen_inc;
                    if (below) begin
                        mid.pending_counted = i_state.pending_counted + 2'd1;
                    end
                    if (i_state.pending_length == bolc_pkg::SEQ_FOUR &&
                        i_state.pending_seen == 2'd0) begin
                        mid.pending_astral = (i_state.pending_lead_bits != 3'd0) ||
                                             (b[5:4] != 2'd0);
                    end
                    if (seen_inc >= i_state.pending_length) begin
                        inc = (i_state.pending_length == bolc_pkg::SEQ_FOUR &&
                               mid.pending_astral) ? 3'd2 : 3'd1;
                        mid.pending_length    = bolc_pkg::SEQ_NONE;
                        mid.pending_seen      = 2'd0;
                        mid.pending_astral    = 1'b0;
                        mid.pending_lead_bits = 3'd0;
                        mid.pending_counted   = 2'd0;
                    end
                end else begin
                    inc = 3'd1 + 3'(i_state.pending_counted);
                    mid.pending_length    = bolc_pkg::SEQ_NONE;
                    mid.pending_seen      = 2'd0;
                    mid.pending_astral    = 1'b0;
                    mid.pending_lead_bits = 3'd0;
                    mid.pending_counted   = 2'd0;
                    do_fresh = below;
                end
            end else begin
                do_fresh = below;
            end

            if (do_fresh) begin
                if (b < bolc_pkg::ASCII_LIMIT) begin
                    if (b == bolc_pkg::NEWLINE) begin
                        newline = 1'b1;
                        inc     = 3'd0;
                    end else begin
                        inc = inc + 3'd1;
                    end
                end else if ((b & bolc_pkg::MASK_LEAD2) == bolc_pkg::CODE_LEAD2) begin
                    mid.pending_length = bolc_pkg::SEQ_TWO;
                end else if ((b & bolc_pkg::MASK_LEAD3) == bolc_pkg::CODE_LEAD3) begin
                    mid.pending_length = bolc_pkg::SEQ_THREE;
                end else if ((b & bolc_pkg::MASK_LEAD4) == bolc_pkg::CODE_LEAD4) begin
                    mid.pending_length    = bolc_pkg::SEQ_FOUR;
                    mid.pending_lead_bits = b[2:0];
                end else begin
                    inc = inc + 3'd1;
                end
            end

            if (i_state.byte_position != bolc_pkg::POS_MAX) begin
                mid.byte_position = i_state.byte_position + 1'b1;
            end
        end

        // A text that ends inside a sequence counts it as a broken one.
        if (i_item.last_byte && mid.pending_length != bolc_pkg::SEQ_NONE) begin
            inc = inc + 3'd1 + 3'(mid.pending_counted);
        end
    end

    assign col_base = newline ? '0 : i_state.column_count;
    assign col_sum  = {1'b0, col_base} + COUNT_WIDTH_P1'(inc);
    assign col_final = col_sum[bolc_pkg::COUNT_WIDTH] ? bolc_pkg::COUNT_MAX :
                       col_sum[bolc_pkg::COUNT_WIDTH-1:0];

    always_comb begin
        o_next              = mid;
        o_next.column_count = col_final;
        if (newline && i_state.line_count != bolc_pkg::COUNT_MAX) begin
            o_next.line_count = i_state.line_count + 1'b1;
        end
        o_result.line_number  = bolc_pkg::sat_out(o_next.line_count);
        o_result.column_units = bolc_pkg::sat_out(col_final);
        if (i_item.last_byte) begin
            o_next = '0;
        end
    end

endmodule

`default_nettype wire

### design/bolc_checker.sv
// ============================================================================
// bolc_checker
// Port-level checks of the byte offset to line and UTF-16 column block.
// ============================================================================
`default_nettype none

module bolc_checker (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      i_in_valid,
    input wire                      o_in_stall,
    input wire bolc_pkg::t_in_item  i_in_data,
    input wire                      o_out_valid,
    input wire                      i_out_stall,
    input wire bolc_pkg::t_out_item o_out_data
);

    // A new result must follow a final input transaction.
    a_result_follows_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            $past(i_in_valid && !o_in_stall && i_in_data.last_byte, 2))
        else $error("result without a final input transaction");

    // The input is held back only by a waiting result.
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with no waiting result");

    a_reset_clears_output : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind byte_offset_to_line_utf16_column bolc_checker u_bolc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
